// File: hw/rtl/pca_pkg.sv
`default_nettype none

package pca_pkg;

  // Pool geometry
  localparam int NUM_CHUNKS      = 64;
  localparam int ALIGNMENT       = 16;
  localparam int MAX_CHUNK_BYTES = 4096;

  localparam int IDX_W   = $clog2(NUM_CHUNKS);      // chunk index
  localparam int LINK_W  = $clog2(NUM_CHUNKS) + 1;  // link, one past the last chunk ends the list
  localparam int CNT_W   = 7;                       // chunk count and live count
  localparam int SIZE_W  = 13;                      // byte sizes
  localparam int ALIGN_SH = $clog2(ALIGNMENT);
  localparam int ADDR_W  = 32;
  localparam int TOTAL_W = 32;
  localparam int USED_W  = 19;
  localparam int CFG_W   = 32;
  localparam int CFG_IDX_W = 2;

  // Register reset values
  localparam logic [SIZE_W-1:0] CHUNK_BYTES_RST   = SIZE_W'(16);
  localparam logic [CNT_W-1:0]  CHUNKS_IN_USE_RST = CNT_W'(64);
  localparam logic [ADDR_W-1:0] POOL_BASE_RST     = '0;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CHUNK_BYTES   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHUNKS_IN_USE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_POOL_BASE     = 2'd2;

  // Result status codes
  typedef logic [1:0] status_t;
  localparam status_t ST_OK       = 2'd0;
  localparam status_t ST_EMPTY    = 2'd1;
  localparam status_t ST_BAD_SIZE = 2'd2;
  localparam status_t ST_BAD_FREE = 2'd3;

  // Operation codes
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_LOOK = 2'b10
  } ctrl_state_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;  // capture the word and start the link read
    logic commit;  // update the pool state and load the result
  } pca_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_busy;  // result register full and not being taken
  } pca_sts_t;

endpackage

`default_nettype wire

// File: hw/rtl/pca_ram.sv
`default_nettype none

module pca_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read, hold between reads
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/pca_ctrl.sv
`default_nettype none

module pca_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire pca_pkg::pca_sts_t sts,
  output pca_pkg::pca_cmd_t      cmd
);

  import pca_pkg::*;

  ctrl_state_t state, state_next;

  // Take a word only when idle
  always_comb begin
    in_stall   = (state != ST_IDLE);
    cmd.accept = (state == ST_IDLE) && in_valid;
    cmd.commit = (state == ST_LOOK) && !sts.out_busy;
  end

  // Advance: idle -> look once accepted, look -> idle once the result is loaded
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (cmd.accept) begin
          state_next = ST_LOOK;
        end
      end
      ST_LOOK: begin
        if (cmd.commit) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/pca_dp.sv
`default_nettype none

module pca_dp (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // configuration
  input  wire logic                              cfg_we,
  input  wire logic [pca_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [pca_pkg::CFG_W-1:0]         cfg_data,
  // input word
  input  wire logic                              op,
  input  wire logic [pca_pkg::SIZE_W-1:0]        request_bytes,
  input  wire logic [pca_pkg::IDX_W-1:0]         chunk_index,
  input  wire logic                              no_pointer,
  // result word
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [1:0]                             status,
  output logic [pca_pkg::IDX_W-1:0]              granted_index,
  output logic [pca_pkg::ADDR_W-1:0]             granted_address,
  output logic [pca_pkg::CNT_W-1:0]              live_chunks,
  output logic [pca_pkg::TOTAL_W-1:0]            alloc_total,
  output logic [pca_pkg::TOTAL_W-1:0]            free_total,
  output logic [pca_pkg::USED_W-1:0]             used_bytes,
  // control
  input  wire pca_pkg::pca_cmd_t                 cmd,
  output pca_pkg::pca_sts_t                      sts
);

  import pca_pkg::*;

  // Configuration registers
  logic [SIZE_W-1:0] chunk_bytes;
  logic [CNT_W-1:0]  chunks_in_use;
  logic [ADDR_W-1:0] pool_base;

  // Pool state
  logic [IDX_W-1:0]      head_index;
  logic                  head_valid;
  logic [CNT_W-1:0]      live_count;
  logic [TOTAL_W-1:0]    alloc_counter;
  logic [TOTAL_W-1:0]    free_counter;
  logic [NUM_CHUNKS-1:0] chunk_taken;
  logic [NUM_CHUNKS-1:0] link_written;

  // Captured word
  logic              op_q;
  logic [SIZE_W-1:0] req_q;
  logic [IDX_W-1:0]  idx_q;
  logic              nullp_q;
  logic              link_written_q;

  // Link memory
  logic              link_we;
  logic [LINK_W-1:0] link_wdata;
  logic [LINK_W-1:0] link_rdata;

  // Derived values
  logic [SIZE_W-1:0] size_sat;
  logic [SIZE_W-1:0] size_round;
  logic [SIZE_W-1:0] csz;
  logic [CNT_W-1:0]  cnt;
  logic [LINK_W-1:0] nxt;
  logic              bad_size;
  logic              empty;
  logic              bad_free;
  logic              do_alloc;
  logic              do_free;
  status_t           status_next;
  logic [ADDR_W-1:0] addr_next;
  logic [CNT_W-1:0]  live_next;
  logic [USED_W-1:0] used_next;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      chunk_bytes   <= CHUNK_BYTES_RST;
      chunks_in_use <= CHUNKS_IN_USE_RST;
      pool_base     <= POOL_BASE_RST;
    end else if (cfg_we) begin
      priority case (cfg_index)
        CFG_CHUNK_BYTES:   chunk_bytes   <= cfg_data[SIZE_W-1:0];
        CFG_CHUNKS_IN_USE: chunks_in_use <= cfg_data[CNT_W-1:0];
        CFG_POOL_BASE:     pool_base     <= cfg_data[ADDR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Aligned chunk size and saturated chunk count
  always_comb begin
    size_sat   = (chunk_bytes > SIZE_W'(MAX_CHUNK_BYTES)) ? SIZE_W'(MAX_CHUNK_BYTES)
                                                          : chunk_bytes;
    size_round = size_sat + SIZE_W'(ALIGNMENT - 1);
    csz        = (size_round >> ALIGN_SH) << ALIGN_SH;
    cnt        = (chunks_in_use > CNT_W'(NUM_CHUNKS)) ? CNT_W'(NUM_CHUNKS) : chunks_in_use;
  end

  // Capture the word; note whether the head's link was ever rewritten
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_q           <= op;
      req_q          <= request_bytes;
      idx_q          <= chunk_index;
      nullp_q        <= no_pointer;
      link_written_q <= link_written[head_index];
    end
  end

  pca_ram #(
    .WIDTH (LINK_W),
    .DEPTH (NUM_CHUNKS)
  ) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (idx_q),
    .wdata (link_wdata),
    .re    (cmd.accept),
    .raddr (head_index),
    .rdata (link_rdata)
  );

  // Decide the outcome of the held word
  always_comb begin
    nxt         = link_written_q ? link_rdata : LINK_W'(head_index) + LINK_W'(1);
    bad_size    = (req_q == '0) || (req_q > csz);
    empty       = !head_valid || (CNT_W'(head_index) >= cnt);
    bad_free    = (CNT_W'(idx_q) >= cnt) || !chunk_taken[idx_q];
    do_alloc    = 1'b0;
    do_free     = 1'b0;
    status_next = ST_OK;
    if (op_q == OP_ALLOC) begin
      if (bad_size) begin
        status_next = ST_BAD_SIZE;
      end else if (empty) begin
        status_next = ST_EMPTY;
      end else begin
        do_alloc = 1'b1;
      end
    end else if (!nullp_q) begin
      if (bad_free) begin
        status_next = ST_BAD_FREE;
      end else begin
        do_free = 1'b1;
      end
    end
    addr_next = pool_base + ADDR_W'(USED_W'(head_index) * USED_W'(csz));
    priority if (do_alloc) begin
      live_next = live_count + CNT_W'(1);
    end else if (do_free && live_count != '0) begin
      live_next = live_count - CNT_W'(1);
    end else begin
      live_next = live_count;
    end
    used_next  = USED_W'(csz) * USED_W'(live_next);
    link_we    = cmd.commit && do_free;
    link_wdata = head_valid ? LINK_W'(head_index) : LINK_W'(NUM_CHUNKS);
  end

  // Update the free list and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      head_index    <= '0;
      head_valid    <= 1'b1;
      live_count    <= '0;
      alloc_counter <= '0;
      free_counter  <= '0;
      chunk_taken   <= '0;
      link_written  <= '0;
    end else if (cmd.commit) begin
      live_count <= live_next;
      if (do_alloc) begin
        chunk_taken[head_index] <= 1'b1;
        alloc_counter           <= alloc_counter + TOTAL_W'(1);
        if (nxt < LINK_W'(cnt)) begin
          head_index <= nxt[IDX_W-1:0];
          head_valid <= 1'b1;
        end else begin
          head_index <= '0;
          head_valid <= 1'b0;
        end
      end else if (do_free) begin
        chunk_taken[idx_q]  <= 1'b0;
        link_written[idx_q] <= 1'b1;
        free_counter        <= free_counter + TOTAL_W'(1);
        head_index          <= idx_q;
        head_valid          <= 1'b1;
      end
    end
  end

  // Result register valid: set on commit, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Load the result word
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      status          <= status_next;
      granted_index   <= do_alloc ? head_index : '0;
      granted_address <= do_alloc ? addr_next : '0;
      live_chunks     <= live_next;
      alloc_total     <= do_alloc ? alloc_counter + TOTAL_W'(1) : alloc_counter;
      free_total      <= do_free ? free_counter + TOTAL_W'(1) : free_counter;
      used_bytes      <= used_next;
    end
  end

  assign sts.out_busy = out_valid && out_stall;

endmodule

`default_nettype wire

// File: hw/rtl/pool_chunk_allocator_top.sv
`default_nettype none

// Channel   Direction  Handshake            Payload
// in        input      in_valid / in_stall  op, request_bytes, chunk_index, no_pointer
// out       output     out_valid/ out_stall status, granted_index, granted_address,
//                                           live_chunks, alloc_total, free_total, used_bytes
// cfg       input      cfg_we               cfg_index, cfg_data
//
// In the idle state a word is captured and the head chunk's link is read from the link RAM;
// in the look state the outcome is settled and the free list updated. A new word is taken
// only after the last one has committed to the result register.
// Reset is ready at once: links not yet rewritten read as the next chunk by a valid bit.
// A stalled result holds the block in the look state until the result is taken.

module pool_chunk_allocator_top (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [pca_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [pca_pkg::CFG_W-1:0]     cfg_data,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic                          op,
  input  wire logic [pca_pkg::SIZE_W-1:0]    request_bytes,
  input  wire logic [pca_pkg::IDX_W-1:0]     chunk_index,
  input  wire logic                          no_pointer,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [1:0]                         status,
  output logic [pca_pkg::IDX_W-1:0]          granted_index,
  output logic [pca_pkg::ADDR_W-1:0]         granted_address,
  output logic [pca_pkg::CNT_W-1:0]          live_chunks,
  output logic [pca_pkg::TOTAL_W-1:0]        alloc_total,
  output logic [pca_pkg::TOTAL_W-1:0]        free_total,
  output logic [pca_pkg::USED_W-1:0]         used_bytes
);

  import pca_pkg::*;

  pca_cmd_t cmd;
  pca_sts_t sts;

  pca_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  pca_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .op              (op),
    .request_bytes   (request_bytes),
    .chunk_index     (chunk_index),
    .no_pointer      (no_pointer),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .status          (status),
    .granted_index   (granted_index),
    .granted_address (granted_address),
    .live_chunks     (live_chunks),
    .alloc_total     (alloc_total),
    .free_total      (free_total),
    .used_bytes      (used_bytes),
    .cmd             (cmd),
    .sts             (sts)
  );

endmodule

`default_nettype wire
